FILE: hdl/sedd_pkg.sv
// shared types, constants and helpers of the serpentine error diffusion dither
`timescale 1ns / 1ps

package sedd_pkg;

  localparam int MaxWidth = 4096;
  localparam int ColW     = 12;
  localparam int ErrW     = 16;
  localparam int TagW     = 32;
  localparam int WordW    = TagW + ErrW;

  localparam logic [12:0] RowWidthReset = 13'd640;
  localparam logic [8:0]  ShadeReset    = 9'd2;
  localparam logic [12:0] RowWidthMax   = 13'd4096;
  localparam logic [8:0]  ShadeMax      = 9'd256;
  localparam logic [15:0] Recip255      = 16'd32897;

  typedef enum logic [0:0] {
    CFG_ROW_WIDTH   = 1'b0,
    CFG_SHADE_COUNT = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_RD0, B_RD1, B_MUL, B_RECIP, B_LVL, B_PREP,
    B_QDIV, B_ERR, B_WR0, B_WR1, B_WR2, B_OUT
  } back_state_t;

  typedef struct packed {
    logic [7:0]      pixel;
    logic [ColW-1:0] col;
    logic [ColW-1:0] nbf;
    logic            nbf_ok;
    logic [ColW-1:0] nbb;
    logic            nbb_ok;
    logic            last;
    logic [TagW-1:0] epoch;
  } item_t;

  typedef struct packed {
    logic             we;
    logic [ColW-1:0]  waddr;
    logic [WordW-1:0] wdata;
    logic [ColW-1:0]  raddr_a;
    logic [ColW-1:0]  raddr_b;
  } bank_req_t;

  typedef struct packed {
    logic [WordW-1:0] rdata_a;
    logic [WordW-1:0] rdata_b;
  } bank_rsp_t;

  function automatic logic [ErrW-1:0] sat16(input logic signed [18:0] x);
    logic [ErrW-1:0] r;
    if (x > 19'sd32767) begin
      r = 16'h7fff;
    end else if (x < -19'sd32768) begin
      r = 16'h8000;
    end else begin
      r = x[ErrW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [18:0] share(input logic signed [17:0] e,
                                               input logic [2:0] k);
    logic signed [22:0] p;
    p = e * $signed({1'b0, k}) + 23'sd8;
    return p[22:4];
  endfunction

endpackage

FILE: hdl/sedd_front.sv
// front end: takes pixels, tracks column, direction and row epoch
`timescale 1ns / 1ps

module sedd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_pixel_in,
  input  logic                in_first_of_image,
  input  logic [12:0]         w_eff,
  input  logic                clearing,
  output logic                push_valid,
  input  logic                push_ready,
  output sedd_pkg::item_t     push_item
);

  logic [sedd_pkg::ColW-1:0] cp_r, cp_nxt;
  logic                      dir_r, dir_nxt;
  logic [sedd_pkg::TagW-1:0] ep_r, ep_nxt;

  logic [sedd_pkg::ColW-1:0] cp_start, cp_use, wm1, col;
  logic                      dir_start;
  logic [sedd_pkg::TagW-1:0] ep_start;
  logic [12:0]               wm1_full;
  logic                      last;

  assign in_ready   = push_ready && !clearing;
  assign push_valid = in_valid && !clearing;

  always_comb begin
    cp_start  = in_first_of_image ? '0 : cp_r;
    dir_start = in_first_of_image ? 1'b0 : dir_r;
    ep_start  = in_first_of_image ? ep_r + 32'd2 : ep_r;
    cp_use    = ({1'b0, cp_start} >= w_eff) ? '0 : cp_start;
    wm1_full  = w_eff - 13'd1;
    wm1       = wm1_full[sedd_pkg::ColW-1:0];
    col       = dir_start ? (wm1 - cp_use) : cp_use;
    last      = (cp_use == wm1);

    push_item.pixel = in_pixel_in;
    push_item.col   = col;
    push_item.last  = last;
    push_item.epoch = ep_start;
    if (!dir_start) begin
      push_item.nbf    = col + 12'd1;
      push_item.nbf_ok = (col != wm1);
      push_item.nbb    = col - 12'd1;
      push_item.nbb_ok = (col != '0);
    end else begin
      push_item.nbf    = col - 12'd1;
      push_item.nbf_ok = (col != '0);
      push_item.nbb    = col + 12'd1;
      push_item.nbb_ok = (col != wm1);
    end

    cp_nxt  = cp_r;
    dir_nxt = dir_r;
    ep_nxt  = ep_r;
    if (in_valid && in_ready) begin
      if (last) begin
        cp_nxt  = '0;
        dir_nxt = !dir_start;
        ep_nxt  = ep_start + 32'd1;
      end else begin
        cp_nxt  = cp_use + 12'd1;
        dir_nxt = dir_start;
        ep_nxt  = ep_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r  <= '0;
      dir_r <= 1'b0;
      ep_r  <= '0;
    end else begin
      cp_r  <= cp_nxt;
      dir_r <= dir_nxt;
      ep_r  <= ep_nxt;
    end
  end

endmodule

FILE: hdl/sedd_queue.sv
// two-word queue between front and back
`timescale 1ns / 1ps

module sedd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  sedd_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sedd_pkg::item_t pop_item
);

  sedd_pkg::item_t slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

FILE: hdl/sedd_bank.sv
// one error row bank: tagged words, one write and two registered reads
`timescale 1ns / 1ps

module sedd_bank (
  input  logic                clk,
  input  sedd_pkg::bank_req_t req,
  output sedd_pkg::bank_rsp_t rsp
);

  logic [sedd_pkg::WordW-1:0] mem [sedd_pkg::MaxWidth];
  logic [sedd_pkg::WordW-1:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a_r <= mem[req.raddr_a];
    rd_b_r <= mem[req.raddr_b];
  end

  assign rsp.rdata_a = rd_a_r;
  assign rsp.rdata_b = rd_b_r;

endmodule

FILE: hdl/sedd_back.sv
// back end: quantises each pixel and spreads its error over the row banks
`timescale 1ns / 1ps

module sedd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      sm1,
  output logic            clearing,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  sedd_pkg::item_t pop_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_pixel_out,
  output logic            out_row_end
);

  sedd_pkg::back_state_t state_r, state_nxt;
  logic [sedd_pkg::ColW-1:0] clr_r, clr_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_pixel_r;
  logic                      out_row_end_r;
  logic                      load_out;

  sedd_pkg::item_t ent_r;
  logic signed [17:0] v_r;
  logic               vpos_r;
  logic [15:0]        curnb_r, nxtcol_r, nxtnb_r, nxtbb_r;
  logic [19:0]        m_r;
  logic [11:0]        q0_r;
  logic [7:0]         lvl_r;
  logic [16:0]        rem_r;
  logic [15:0]        dv_r;
  logic [2:0]         bit_r;
  logic [7:0]         q_r;
  logic [15:0]        wcur_r, wcol_r, wnb_r, wbb_r;

  sedd_pkg::bank_req_t cur_req, nxt_req, req0, req1;
  sedd_pkg::bank_rsp_t rsp0, rsp1, cur_rsp, nxt_rsp;
  logic [sedd_pkg::TagW-1:0] ep_next;

  logic signed [17:0] v_calc, e_calc;
  logic [24:0]        prod;
  logic [25:0]        n2;
  logic [35:0]        rprod;
  logic [19:0]        q0x255;
  logic [11:0]        lc;
  logic [16:0]        rem_init;
  logic               ge;

  sedd_bank u_bank0 (.clk(clk), .req(req0), .rsp(rsp0));
  sedd_bank u_bank1 (.clk(clk), .req(req1), .rsp(rsp1));

  assign ep_next       = ent_r.epoch + 32'd1;
  assign cur_rsp       = ent_r.epoch[0] ? rsp1 : rsp0;
  assign nxt_rsp       = ent_r.epoch[0] ? rsp0 : rsp1;
  assign clearing      = (state_r == sedd_pkg::B_CLEAR);
  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_row_end   = out_row_end_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    pop_ready = 1'b0;
    load_out  = 1'b0;
    cur_req   = '0;
    nxt_req   = '0;
    cur_req.raddr_a = ent_r.col;
    cur_req.raddr_b = ent_r.nbf;
    nxt_req.raddr_a = ent_r.col;
    nxt_req.raddr_b = ent_r.nbf;
    unique case (state_r)
      sedd_pkg::B_CLEAR: begin
        clr_nxt = clr_r + 12'd1;
        if (clr_r == 12'hfff) begin
          state_nxt = sedd_pkg::B_IDLE;
        end
      end
      sedd_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_nxt = sedd_pkg::B_RD0;
        end
      end
      sedd_pkg::B_RD0:   state_nxt = sedd_pkg::B_RD1;
      sedd_pkg::B_RD1: begin
        nxt_req.raddr_a = ent_r.nbb;
        state_nxt = sedd_pkg::B_MUL;
      end
      sedd_pkg::B_MUL:   state_nxt = sedd_pkg::B_RECIP;
      sedd_pkg::B_RECIP: state_nxt = sedd_pkg::B_LVL;
      sedd_pkg::B_LVL:   state_nxt = sedd_pkg::B_PREP;
      sedd_pkg::B_PREP:  state_nxt = sedd_pkg::B_QDIV;
      sedd_pkg::B_QDIV: begin
        if (bit_r == 3'd0) begin
          state_nxt = sedd_pkg::B_ERR;
        end
      end
      sedd_pkg::B_ERR:   state_nxt = sedd_pkg::B_WR0;
      sedd_pkg::B_WR0: begin
        cur_req.we    = ent_r.nbf_ok;
        cur_req.waddr = ent_r.nbf;
        cur_req.wdata = {ent_r.epoch, wcur_r};
        nxt_req.we    = 1'b1;
        nxt_req.waddr = ent_r.col;
        nxt_req.wdata = {ep_next, wcol_r};
        state_nxt = sedd_pkg::B_WR1;
      end
      sedd_pkg::B_WR1: begin
        nxt_req.we    = ent_r.nbf_ok;
        nxt_req.waddr = ent_r.nbf;
        nxt_req.wdata = {ep_next, wnb_r};
        state_nxt = sedd_pkg::B_WR2;
      end
      sedd_pkg::B_WR2: begin
        nxt_req.we    = ent_r.nbb_ok;
        nxt_req.waddr = ent_r.nbb;
        nxt_req.wdata = {ep_next, wbb_r};
        state_nxt = sedd_pkg::B_OUT;
      end
      sedd_pkg::B_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = sedd_pkg::B_IDLE;
        end
      end
      default: state_nxt = sedd_pkg::B_IDLE;
    endcase

    if (state_r == sedd_pkg::B_CLEAR) begin
      req0 = '0;
      req0.we    = 1'b1;
      req0.waddr = clr_r;
      req0.wdata = {{sedd_pkg::TagW{1'b1}}, {sedd_pkg::ErrW{1'b0}}};
      req1 = req0;
    end else begin
      req0 = ent_r.epoch[0] ? nxt_req : cur_req;
      req1 = ent_r.epoch[0] ? cur_req : nxt_req;
    end

    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sedd_pkg::B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_comb begin
    v_calc = $signed({6'd0, ent_r.pixel, 4'd0}) +
             ((cur_rsp.rdata_a[47:16] == ent_r.epoch) ?
              18'(signed'(cur_rsp.rdata_a[15:0])) : 18'sd0);
    prod     = v_r[16:0] * sm1;
    n2       = {prod, 1'b0} + 26'd4080;
    rprod    = m_r * sedd_pkg::Recip255;
    q0x255   = {q0_r, 8'd0} - {8'd0, q0_r};
    lc       = (q0x255 > m_r) ? (q0_r - 12'd1) : q0_r;
    rem_init = ({9'd0, lvl_r} * 17'd510) + {9'd0, sm1};
    ge       = (rem_r >= {1'b0, dv_r});
    e_calc   = v_r - $signed({6'd0, q_r, 4'd0});
  end

  always_ff @(posedge clk) begin
    if (state_r == sedd_pkg::B_IDLE && pop_valid) begin
      ent_r <= pop_item;
    end
    if (state_r == sedd_pkg::B_RD1) begin
      v_r      <= v_calc;
      curnb_r  <= (cur_rsp.rdata_b[47:16] == ent_r.epoch) ? cur_rsp.rdata_b[15:0] : '0;
      nxtcol_r <= (nxt_rsp.rdata_a[47:16] == ep_next) ? nxt_rsp.rdata_a[15:0] : '0;
      nxtnb_r  <= (nxt_rsp.rdata_b[47:16] == ep_next) ? nxt_rsp.rdata_b[15:0] : '0;
    end
    if (state_r == sedd_pkg::B_MUL) begin
      nxtbb_r <= (nxt_rsp.rdata_a[47:16] == ep_next) ? nxt_rsp.rdata_a[15:0] : '0;
      vpos_r  <= (v_r > 18'sd0);
      m_r     <= n2[24:5];
    end
    if (state_r == sedd_pkg::B_RECIP) begin
      q0_r <= rprod[34:23];
    end
    if (state_r == sedd_pkg::B_LVL) begin
      if (!vpos_r) begin
        lvl_r <= 8'd0;
      end else if (lc > {4'd0, sm1}) begin
        lvl_r <= sm1;
      end else begin
        lvl_r <= lc[7:0];
      end
    end
    if (state_r == sedd_pkg::B_PREP) begin
      rem_r <= rem_init;
      dv_r  <= {sm1, 8'd0};
      bit_r <= 3'd7;
      q_r   <= 8'd0;
    end
    if (state_r == sedd_pkg::B_QDIV) begin
      if (ge) begin
        rem_r <= rem_r - {1'b0, dv_r};
      end
      q_r   <= {q_r[6:0], ge};
      dv_r  <= {1'b0, dv_r[15:1]};
      bit_r <= bit_r - 3'd1;
    end
    if (state_r == sedd_pkg::B_ERR) begin
      wcur_r <= sedd_pkg::sat16(19'(signed'(curnb_r)) + sedd_pkg::share(e_calc, 3'd7));
      wcol_r <= sedd_pkg::sat16(19'(signed'(nxtcol_r)) + sedd_pkg::share(e_calc, 3'd5));
      wnb_r  <= sedd_pkg::sat16(19'(signed'(nxtnb_r)) + sedd_pkg::share(e_calc, 3'd1));
      wbb_r  <= sedd_pkg::sat16(19'(signed'(nxtbb_r)) + sedd_pkg::share(e_calc, 3'd3));
    end
    if (load_out) begin
      out_pixel_r   <= q_r;
      out_row_end_r <= ent_r.last;
    end
  end

endmodule

FILE: hdl/serpentine_error_diffusion_dither.sv
// top level of the serpentine error diffusion dither
`timescale 1ns / 1ps

// Grey pixels enter in serpentine order and leave as dithered levels, one word
// out per word in. In the back end a pixel goes through two bank reads, the
// multiply, reciprocal and level steps that find the level, an 8-step
// bit-serial divide that maps the level back to a grey value, three writes
// through the single write port of the next-row bank, and the hand-off to the
// output register. The front end and a two-word queue take the next pixels
// meanwhile. After reset all 4096 words of the error banks are swept clean;
// no pixel is taken during the sweep, but configuration writes are taken throughout.
module serpentine_error_diffusion_dither (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_in,
  input  logic        in_first_of_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_out,
  output logic        out_row_end
);

  logic [12:0] row_width_r, row_width_nxt;
  logic [8:0]  shade_count_r, shade_count_nxt;
  logic [12:0] w_eff;
  logic [8:0]  s_eff, s_m1;
  logic [7:0]  sm1;
  logic        clearing;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  sedd_pkg::item_t push_item, pop_item;

  always_comb begin
    row_width_nxt   = row_width_r;
    shade_count_nxt = shade_count_r;
    if (cfg_we) begin
      unique case (sedd_pkg::cfg_index_t'(cfg_index))
        sedd_pkg::CFG_ROW_WIDTH:   row_width_nxt   = cfg_wdata;
        sedd_pkg::CFG_SHADE_COUNT: shade_count_nxt = cfg_wdata[8:0];
        default: ;
      endcase
    end
    if (row_width_r == 13'd0) begin
      w_eff = 13'd1;
    end else if (row_width_r > sedd_pkg::RowWidthMax) begin
      w_eff = sedd_pkg::RowWidthMax;
    end else begin
      w_eff = row_width_r;
    end
    if (shade_count_r < 9'd2) begin
      s_eff = 9'd2;
    end else if (shade_count_r > sedd_pkg::ShadeMax) begin
      s_eff = sedd_pkg::ShadeMax;
    end else begin
      s_eff = shade_count_r;
    end
    s_m1 = s_eff - 9'd1;
    sm1  = s_m1[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= sedd_pkg::RowWidthReset;
      shade_count_r <= sedd_pkg::ShadeReset;
    end else begin
      row_width_r   <= row_width_nxt;
      shade_count_r <= shade_count_nxt;
    end
  end

  sedd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel_in(in_pixel_in), .in_first_of_image(in_first_of_image),
    .w_eff(w_eff), .clearing(clearing),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
  );

  sedd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
  );

  sedd_back u_back (
    .clk(clk), .rst_n(rst_n), .sm1(sm1), .clearing(clearing),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_out(out_pixel_out), .out_row_end(out_row_end)
  );

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("word taken during bank sweep");

  a_queue_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !pop_valid)
    else $error("queue holds words during bank sweep");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid)
    else $error("result shown during bank sweep");

endmodule
